### design/tpsd_pkg.sv
package tpsd_pkg;

  // Widths fixed by the register map and the word fields
  localparam int TOTAL_BITS = 24;
  localparam int CFG_DATA_BITS = 24;
  localparam int CFG_INDEX_BITS = 2;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_PIXEL_FORMAT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RLE_ENABLE = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PIXEL_TOTAL = 2'd2;

  // Pixel format codes
  localparam logic [2:0] FMT_GRAY8 = 3'd0;
  localparam logic [2:0] FMT_GRAY16 = 3'd1;
  localparam logic [2:0] FMT_RGB555 = 3'd2;
  localparam logic [2:0] FMT_BGR24 = 3'd3;
  localparam logic [2:0] FMT_BGRA32 = 3'd4;
  localparam logic [2:0] FMT_INDEXED8 = 3'd5;

  // Input word actions
  localparam logic ACT_IMAGE_BYTE = 1'b0;
  localparam logic ACT_PALETTE_WRITE = 1'b1;

  // Packet phase codes
  localparam logic [1:0] PHASE_HEADER = 2'd0;
  localparam logic [1:0] PHASE_RUN = 2'd1;
  localparam logic [1:0] PHASE_RAW = 2'd2;

  // Packet header fields and RGB555 channel masks
  localparam logic [7:0] HDR_COUNT_MASK = 8'h7f;
  localparam logic [7:0] HDR_RUN_MASK = 8'h80;
  localparam logic [15:0] RGB555_RED_MASK = 16'h7C00;
  localparam logic [15:0] RGB555_GREEN_MASK = 16'h03E0;
  localparam logic [15:0] RGB555_BLUE_MASK = 16'h001F;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic action;
    logic [7:0] data_byte;
    logic [7:0] palette_index;
    logic [7:0] palette_red;
    logic [7:0] palette_green;
    logic [7:0] palette_blue;
  } in_word_t;

  typedef struct packed {
    logic [7:0] comp_first;
    logic [7:0] comp_second;
    logic [7:0] comp_third;
    logic [7:0] comp_fourth;
    logic [7:0] repeat_count;
    logic image_done;
    logic run_clipped;
  } out_word_t;

  // One queued piece of work: a palette write or a completed pixel
  typedef struct packed {
    logic is_palette;
    logic [7:0] pal_index;
    logic [23:0] pal_rgb;
    logic [31:0] px;
    logic [2:0] fmt;
    logic [7:0] rep;
    logic done;
    logic clip;
  } entry_t;

  typedef struct packed {
    logic full;
    logic head_valid;
  } q_status_t;

  function automatic logic [2:0] bytes_per_pixel(input logic [2:0] fmt);
    logic [2:0] n;
    case (fmt)
      FMT_GRAY16, FMT_RGB555: n = 3'd2;
      FMT_BGR24: n = 3'd3;
      FMT_BGRA32: n = 3'd4;
      default: n = 3'd1;
    endcase
    return n;
  endfunction

endpackage

### design/tpsd_front.sv
module tpsd_front import tpsd_pkg::*; #(
  parameter int COUNT_BITS = 24
) (
  input  logic clk,
  input  logic rst,
  input  logic [2:0] pixel_format,
  input  logic rle_enable,
  input  logic [TOTAL_BITS-1:0] pixel_total,
  input  logic item_valid,
  output logic item_ready,
  input  in_word_t item,
  input  q_status_t q_status,
  output logic push,
  output entry_t push_entry
);

  localparam int TW = (COUNT_BITS > TOTAL_BITS) ? COUNT_BITS : TOTAL_BITS;
  localparam logic [TW-1:0] COUNT_MAX = TW'((64'd1 << COUNT_BITS) - 64'd1);

  logic [1:0] phase, phase_next;
  logic [7:0] packet_left, packet_left_next;
  logic [1:0] byte_in_pixel, byte_in_pixel_next;
  logic [31:0] pixel_bytes, pixel_bytes_next;
  logic [COUNT_BITS-1:0] emitted, emitted_next;
  logic clip_flag, clip_flag_next;

  logic accept;
  logic [TW-1:0] total_ext, total_eff, emitted_ext, remaining;
  logic image_over;
  logic [7:0] hdr_count;
  logic [2:0] bpp, bip_inc;
  logic [31:0] px_full;
  logic [7:0] rep, rep_clamped;
  logic done;

  assign item_ready = !q_status.full;
  assign accept = item_valid && item_ready;

  // Work out the effective total and what remains of it
  always_comb begin
    total_ext = TW'(pixel_total);
    total_eff = (total_ext < COUNT_MAX) ? total_ext : COUNT_MAX;
    emitted_ext = TW'(emitted);
    remaining = total_eff - emitted_ext;
    image_over = emitted_ext >= total_eff;
    hdr_count = {1'b0, item.data_byte[6:0] & HDR_COUNT_MASK[6:0]} + 8'd1;
    bpp = bytes_per_pixel(pixel_format);
    bip_inc = {1'b0, byte_in_pixel} + 3'd1;
    px_full = pixel_bytes | (32'(item.data_byte) << {byte_in_pixel, 3'b000});
  end

  // Classify the byte and advance packet and pixel state
  always_comb begin
    phase_next = phase;
    packet_left_next = packet_left;
    byte_in_pixel_next = byte_in_pixel;
    pixel_bytes_next = pixel_bytes;
    emitted_next = emitted;
    clip_flag_next = clip_flag;
    rep = 8'd1;
    rep_clamped = 8'd1;
    done = 1'b0;
    push = 1'b0;
    push_entry = '0;
    push_entry.fmt = pixel_format;
    if (accept && item.action == ACT_PALETTE_WRITE) begin
      push = 1'b1;
      push_entry.is_palette = 1'b1;
      push_entry.pal_index = item.palette_index;
      push_entry.pal_rgb = {item.palette_red, item.palette_green, item.palette_blue};
    end else if (accept && !image_over) begin
      if (rle_enable && phase != PHASE_RUN && phase != PHASE_RAW) begin
        // Packet header: load count, clipped to what remains
        if (TW'(hdr_count) > remaining) begin
          packet_left_next = remaining[7:0];
          clip_flag_next = 1'b1;
        end else begin
          packet_left_next = hdr_count;
          clip_flag_next = 1'b0;
        end
        phase_next = ((item.data_byte & HDR_RUN_MASK) != 8'd0) ? PHASE_RUN : PHASE_RAW;
        byte_in_pixel_next = 2'd0;
        pixel_bytes_next = '0;
      end else if (bip_inc < bpp) begin
        // Gather another byte of the pixel
        pixel_bytes_next = px_full;
        byte_in_pixel_next = bip_inc[1:0];
      end else begin
        // Pixel complete: settle its repeat and queue it
        byte_in_pixel_next = 2'd0;
        pixel_bytes_next = '0;
        if (rle_enable) begin
          if (phase == PHASE_RUN) begin
            rep = (packet_left == 8'd0) ? 8'd1 : packet_left;
            packet_left_next = 8'd0;
          end else begin
            packet_left_next = (packet_left > 8'd0) ? packet_left - 8'd1 : 8'd0;
          end
          if (packet_left_next == 8'd0) begin
            phase_next = PHASE_HEADER;
          end
        end
        rep_clamped = (TW'(rep) > remaining) ? remaining[7:0] : rep;
        emitted_next = emitted + COUNT_BITS'(rep_clamped);
        done = TW'(emitted_next) >= total_eff;
        if (done) begin
          clip_flag_next = 1'b0;
        end
        push = 1'b1;
        push_entry.px = px_full;
        push_entry.rep = rep_clamped;
        push_entry.done = done;
        push_entry.clip = done && rle_enable && clip_flag;
      end
    end
  end

  // Hold decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PHASE_HEADER;
      packet_left <= '0;
      byte_in_pixel <= '0;
      pixel_bytes <= '0;
      emitted <= '0;
      clip_flag <= 1'b0;
    end else begin
      phase <= phase_next;
      packet_left <= packet_left_next;
      byte_in_pixel <= byte_in_pixel_next;
      pixel_bytes <= pixel_bytes_next;
      emitted <= emitted_next;
      clip_flag <= clip_flag_next;
    end
  end

endmodule

### design/tpsd_queue.sv
module tpsd_queue import tpsd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  entry_t push_entry,
  input  logic pop,
  output q_status_t q_status,
  output entry_t head
);

  entry_t slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_PTR_BITS:0] count;
  logic do_push, do_pop;

  assign q_status.full = count == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH);
  assign q_status.head_valid = count != '0;
  assign do_push = push && !q_status.full;
  assign do_pop = pop && q_status.head_valid;
  assign head = slots[rd_ptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### design/tpsd_back.sv
module tpsd_back import tpsd_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic clk,
  input  logic rst,
  input  q_status_t q_status,
  input  entry_t head,
  output logic pop,
  output logic pixel_valid,
  input  logic pixel_ready,
  output out_word_t pixel
);

  localparam int AW = $clog2(PALETTE_DEPTH);

  logic [23:0] palette [PALETTE_DEPTH];
  entry_t s1;
  logic s1_valid, s1_hit;
  logic [23:0] s1_rgb;
  logic adv_out, s1_free, write_hit, pop_pixel;
  logic [7:0] b0, b1, b2, b3;
  logic [15:0] w;
  out_word_t decoded;

  assign adv_out = !pixel_valid || pixel_ready;
  assign s1_free = !s1_valid || adv_out;
  assign pop = q_status.head_valid && (head.is_palette || s1_free);
  assign pop_pixel = pop && !head.is_palette;
  assign write_hit = {1'b0, head.pal_index} < 9'(PALETTE_DEPTH);

  // Write palette entries and read the entry for the next pixel
  always_ff @(posedge clk) begin
    if (pop && head.is_palette && write_hit) begin
      palette[head.pal_index[AW-1:0]] <= head.pal_rgb;
    end
    if (pop_pixel) begin
      s1_rgb <= palette[head.px[AW-1:0]];
    end
  end

  // Hold the pixel alongside its palette read
  always_ff @(posedge clk) begin
    if (pop_pixel) begin
      s1 <= head;
      s1_hit <= {1'b0, head.px[7:0]} < 9'(PALETTE_DEPTH);
    end
  end

  // Rebuild channels in RGBA order
  always_comb begin
    b0 = s1.px[7:0];
    b1 = s1.px[15:8];
    b2 = s1.px[23:16];
    b3 = s1.px[31:24];
    w = {b1, b0};
    decoded = '0;
    case (s1.fmt)
      FMT_GRAY16: begin
        decoded.comp_first = b0;
        decoded.comp_second = b1;
      end
      FMT_RGB555: begin
        decoded.comp_first = {5'((w & RGB555_RED_MASK) >> 10), 3'b000};
        decoded.comp_second = {5'((w & RGB555_GREEN_MASK) >> 5), 3'b000};
        decoded.comp_third = {5'(w & RGB555_BLUE_MASK), 3'b000};
      end
      FMT_BGR24: begin
        decoded.comp_first = b2;
        decoded.comp_second = b1;
        decoded.comp_third = b0;
      end
      FMT_BGRA32: begin
        decoded.comp_first = b2;
        decoded.comp_second = b1;
        decoded.comp_third = b0;
        decoded.comp_fourth = b3;
      end
      FMT_INDEXED8: begin
        if (s1_hit) begin
          decoded.comp_first = s1_rgb[23:16];
          decoded.comp_second = s1_rgb[15:8];
          decoded.comp_third = s1_rgb[7:0];
        end
      end
      default: begin
        decoded.comp_first = b0;
      end
    endcase
    decoded.repeat_count = s1.rep;
    decoded.image_done = s1.done;
    decoded.run_clipped = s1.clip;
  end

  // Advance the read stage and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      pixel_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= pop_pixel;
      end
      if (adv_out) begin
        pixel_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && s1_valid) begin
      pixel <= decoded;
    end
  end

endmodule

### design/tga_pixel_stream_decoder_core.sv
// TGA pixel-section decoder, raw or run-length coded.
// Input channel item_valid/item_ready/item: one word per cycle, either an
// image data byte or a palette entry write (action selects which).
// Output channel pixel_valid/pixel_ready/pixel: one word per completed
// pixel, colour channels in RGBA order with a repeat count, image_done on
// the word that completes pixel_total and run_clipped when the last packet
// was cut short. Header bytes, partial pixel bytes, palette writes and bytes
// after the image end give no output word.
// Configuration: cfg_we/cfg_index/cfg_data write pixel_format, rle_enable
// and pixel_total; write them only while the decoder is idle.
// Throughput: one input word per cycle while item_ready is high. A pixel's
// word passes from the byte that completes it through the four-entry queue,
// the registered palette read and the output register.
// Reset: synchronous; clears packet and pixel state, the pixel counter, the
// queue and the registers. Palette contents are undefined until written.
// Stall: while pixel_ready is low the output holds, the back end stops and
// the queue fills; item_ready then drops until space frees.
module tga_pixel_stream_decoder_core import tpsd_pkg::*; #(
  parameter int PALETTE_DEPTH = 256,
  parameter int COUNT_BITS = 24
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic item_valid,
  output logic item_ready,
  input  in_word_t item,
  output logic pixel_valid,
  input  logic pixel_ready,
  output out_word_t pixel
);

  logic [2:0] pixel_format;
  logic rle_enable;
  logic [TOTAL_BITS-1:0] pixel_total;
  logic push, pop;
  entry_t push_entry, head;
  q_status_t q_status;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= FMT_GRAY8;
      rle_enable <= 1'b0;
      pixel_total <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PIXEL_FORMAT: pixel_format <= cfg_data[2:0];
        REG_RLE_ENABLE: rle_enable <= cfg_data[0];
        REG_PIXEL_TOTAL: pixel_total <= cfg_data[TOTAL_BITS-1:0];
        default: pixel_total <= pixel_total;
      endcase
    end
  end

  tpsd_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .pixel_format(pixel_format),
    .rle_enable(rle_enable),
    .pixel_total(pixel_total),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .q_status(q_status),
    .push(push),
    .push_entry(push_entry)
  );

  tpsd_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_entry(push_entry),
    .pop(pop),
    .q_status(q_status),
    .head(head)
  );

  tpsd_back #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_status(q_status),
    .head(head),
    .pop(pop),
    .pixel_valid(pixel_valid),
    .pixel_ready(pixel_ready),
    .pixel(pixel)
  );

`ifndef NO_ASSERTIONS
  // Front never pushes into a full queue
  assert property (@(posedge clk) disable iff (rst) !(push && q_status.full))
    else $error("push into full queue");

  // Every output word covers between one and 128 pixels
  assert property (@(posedge clk) disable iff (rst)
    pixel_valid |-> (pixel.repeat_count != 8'd0 && pixel.repeat_count <= 8'd128))
    else $error("repeat count out of range");

  // A clipped run is only reported on the word that ends the image
  assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel.run_clipped |-> pixel.image_done)
    else $error("run clipped without image end");
`endif

endmodule
